### sv/c8_pkg.sv
package c8_pkg;
	localparam int MEM_BYTES = 4096;
	localparam int STACK_DEPTH = 16;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam logic [11:0] START_RST = 12'h200;
	localparam logic [15:0] SEED_RST = 16'hACE1;
	localparam logic [15:0] LFSR_MASK = 16'hB400;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_EXEC = 2'd1;
	localparam logic [1:0] CMD_ROW = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam logic [0:0] CFG_START = 1'b0;
	localparam logic [0:0] CFG_SEED = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [11:0] mem_address;
		logic [7:0] mem_data;
		logic [4:0] display_row;
		logic [15:0] key_mask;
	} in_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic [63:0] row_pixels;
		logic redraw;
		logic sound_on;
		logic waiting_key;
		logic bad_opcode;
	} out_t;

	// controller -> datapath
	typedef enum logic [3:0] {
		OP_NONE, OP_FETCH_HI, OP_FETCH_LO, OP_DECODE, OP_EXEC, OP_CLS, OP_SPR_RD,
		OP_SPR_ROW, OP_SPR_END, OP_BCD, OP_DUMP, OP_LOAD_RD, OP_LOAD_WR, OP_MEMWR,
		OP_ROWRD, OP_FINISH
	} dop_t;

	typedef struct packed {
		dop_t op;
		logic [5:0] cnt;
	} ctl_t;

	typedef enum logic [1:0] {
		K_SIMPLE, K_CLS, K_SPRITE, K_MULTI
	} kind_t;

	typedef enum logic [1:0] {
		M_BCD, M_DUMP, M_LOAD
	} sub_t;

	typedef struct packed {
		kind_t kind;
		sub_t sub;
		logic [4:0] len;
	} sts_t;

	function automatic logic [7:0] font_byte(input logic [6:0] a);
		logic [7:0] f [80];
		f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
			8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
			8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
			8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
			8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
			8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
			8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
			8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80};
		return (a < 7'd80) ? f[a] : 8'h00;
	endfunction
endpackage

### sv/chip8_interpreter_core.sv
// CHIP-8 core. Pulse start with busy low to issue one command; the result
// appears for one cycle with done high, in the cycle busy drops, and cannot
// be stalled. A write or row read passes an access and a finish state; an
// execute fetches, decodes, executes, then clears each frame row (clear),
// reads and XORs each sprite row (sprite), writes each byte (BCD/store) or
// reads then writes each byte (load). The next command can be taken in the
// done cycle. After reset busy stays high while memory is cleared and the
// font loaded. Make configuration writes only while busy is low; unchecked.
module chip8_interpreter_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input c8_pkg::in_t in_item,
	output logic done,
	output c8_pkg::out_t result,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data
);
	import c8_pkg::*;
	ctl_t ctl;
	sts_t sts;
	c8_ctrl u_ctrl (.clk, .arst_n, .start, .cmd(in_item.cmd), .sts, .ctl, .busy);
	c8_datapath u_dp (.clk, .arst_n, .start, .busy, .in_item, .cfg_we,
		.cfg_index(cfg_index), .cfg_data, .ctl, .sts, .result_valid(done), .result);
endmodule

### sv/c8_ctrl.sv
module c8_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] cmd,
	input c8_pkg::sts_t sts,
	output c8_pkg::ctl_t ctl,
	output logic busy
);
	import c8_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE = 14'h0001, S_CLR = 14'h0002,
		S_FH = 14'h0004, S_FL = 14'h0008,
		S_DEC = 14'h0010, S_EX = 14'h0020,
		S_CLS = 14'h0040, S_SRD = 14'h0080,
		S_SROW = 14'h0100, S_SEND = 14'h0200,
		S_MULT = 14'h0400, S_LWR = 14'h0800,
		S_FIN = 14'h1000, S_ONE = 14'h2000
	} st_t;

	st_t st_q;
	logic [12:0] cnt_q;
	logic [1:0] cmd_q;

	assign busy = (st_q != S_IDLE);

	// reset sweep: clears memory and loads the font, one byte per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			cnt_q <= '0;
			cmd_q <= CMD_WRITE;
		end else begin
			unique case (st_q)
				S_IDLE: if (start) begin
					cmd_q <= cmd;
					cnt_q <= '0;
					st_q <= (cmd == CMD_EXEC) ? S_FH : S_ONE;
				end
				S_CLR: begin
					cnt_q <= cnt_q + 13'd1;
					if (cnt_q == 13'(MEM_BYTES - 1)) st_q <= S_IDLE;
				end
				S_ONE: st_q <= S_FIN;
				S_FH: st_q <= S_FL;
				S_FL: st_q <= S_DEC;
				S_DEC: st_q <= S_EX;
				S_EX: begin
					cnt_q <= '0;
					unique case (sts.kind)
						K_SIMPLE: st_q <= S_FIN;
						K_CLS: st_q <= S_CLS;
						K_SPRITE: st_q <= (sts.len == 5'd0) ? S_SEND : S_SRD;
						K_MULTI: st_q <= S_MULT;
					endcase
				end
				S_CLS: begin
					cnt_q <= cnt_q + 13'd1;
					if (cnt_q == 13'd31) st_q <= S_FIN;
				end
				S_SRD: st_q <= S_SROW;
				S_SROW: begin
					cnt_q <= cnt_q + 13'd1;
					st_q <= (cnt_q[4:0] + 5'd1 == sts.len) ? S_SEND : S_SRD;
				end
				S_SEND: st_q <= S_FIN;
				S_MULT: begin
					if (sts.sub == M_LOAD) st_q <= S_LWR;
					else begin
						cnt_q <= cnt_q + 13'd1;
						if (cnt_q[4:0] + 5'd1 == sts.len) st_q <= S_FIN;
					end
				end
				S_LWR: begin
					cnt_q <= cnt_q + 13'd1;
					st_q <= (cnt_q[4:0] + 5'd1 == sts.len) ? S_FIN : S_MULT;
				end
				S_FIN: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.cnt = cnt_q[5:0];
		unique case (st_q)
			S_CLR: ctl.op = OP_NONE;
			S_ONE: ctl.op = (cmd_q == CMD_WRITE) ? OP_MEMWR :
				(cmd_q == CMD_ROW) ? OP_ROWRD : OP_NONE;
			S_FH: ctl.op = OP_FETCH_HI;
			S_FL: ctl.op = OP_FETCH_LO;
			S_DEC: ctl.op = OP_DECODE;
			S_EX: ctl.op = OP_EXEC;
			S_CLS: ctl.op = OP_CLS;
			S_SRD: ctl.op = OP_SPR_RD;
			S_SROW: ctl.op = OP_SPR_ROW;
			S_SEND: ctl.op = OP_SPR_END;
			S_MULT: ctl.op = (sts.sub == M_BCD) ? OP_BCD :
				(sts.sub == M_DUMP) ? OP_DUMP : OP_LOAD_RD;
			S_LWR: ctl.op = OP_LOAD_WR;
			S_FIN: ctl.op = OP_FINISH;
			default: ctl.op = OP_NONE;
		endcase
		if (st_q == S_CLR) ctl.cnt = '0;
	end
endmodule

### sv/c8_datapath.sv
module c8_datapath (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input c8_pkg::in_t in_item,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	input c8_pkg::ctl_t ctl,
	output c8_pkg::sts_t sts,
	output logic result_valid,
	output c8_pkg::out_t result
);
	import c8_pkg::*;

	logic [7:0] mem [MEM_BYTES];
	logic [63:0] fb [32];
	logic [7:0] v_q [16];
	logic [11:0] stk [STACK_DEPTH];
	logic [15:0] i_q, lfsr_q;
	logic [11:0] pc_q;
	logic [SP_W-1:0] sp_q;
	logic [7:0] dt_q, st_q;
	in_t it_q;
	logic [15:0] op_q;
	logic [7:0] rd_q;
	logic [11:0] raddr;
	logic [63:0] row_q;
	logic red_q, wait_q, bad_q, hit_q;
	logic [11:0] clr_q;
	logic clr_busy_q;

	wire [3:0] x = op_q[11:8];
	wire [3:0] y = op_q[7:4];
	wire [7:0] nn = op_q[7:0];
	wire [3:0] n = op_q[3:0];
	wire [7:0] vx = v_q[x];
	wire [7:0] vy = v_q[y];
	wire [11:0] nxt = pc_q + 12'd2;
	wire [11:0] skp = pc_q + 12'd4;
	wire [3:0] ci = ctl.cnt[3:0];
	wire [11:0] ia = i_q[11:0] + {6'd0, ctl.cnt};
	wire [15:0] lfsr_nx = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_MASK : 16'h0);

	// decode class for controller
	always_comb begin
		sts.kind = K_SIMPLE; sts.sub = M_BCD; sts.len = 5'd0;
		if (op_q == 16'h00E0) sts.kind = K_CLS;
		else if (op_q[15:12] == 4'hD) begin
			sts.kind = K_SPRITE; sts.len = {1'b0, n};
		end else if (op_q[15:12] == 4'hF) begin
			if (nn == 8'h33) begin sts.kind = K_MULTI; sts.sub = M_BCD; sts.len = 5'd3; end
			if (nn == 8'h55) begin
				sts.kind = K_MULTI; sts.sub = M_DUMP; sts.len = {1'b0, x} + 5'd1;
			end
			if (nn == 8'h65) begin
				sts.kind = K_MULTI; sts.sub = M_LOAD; sts.len = {1'b0, x} + 5'd1;
			end
		end
	end

	// lowest pressed key
	logic [3:0] key_lo;
	always_comb begin
		key_lo = 4'd0;
		for (int k = 15; k >= 0; k--)
			if (it_q.key_mask[k]) key_lo = 4'(k);
	end

	// BCD digits; 8-bit value, small constant compares
	logic [7:0] bcd_d;
	always_comb begin
		logic [7:0] t;
		t = vx;
		if (t >= 8'd200) t = t - 8'd200; else if (t >= 8'd100) t = t - 8'd100;
		unique case (ci)
			4'd0: bcd_d = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
			4'd1: bcd_d = (t >= 8'd90) ? 8'd9 : (t >= 8'd80) ? 8'd8 : (t >= 8'd70) ? 8'd7 :
				(t >= 8'd60) ? 8'd6 : (t >= 8'd50) ? 8'd5 : (t >= 8'd40) ? 8'd4 :
				(t >= 8'd30) ? 8'd3 : (t >= 8'd20) ? 8'd2 : (t >= 8'd10) ? 8'd1 : 8'd0;
			default: bcd_d = t - 8'd10 * ((t >= 8'd90) ? 8'd9 : (t >= 8'd80) ? 8'd8 :
				(t >= 8'd70) ? 8'd7 : (t >= 8'd60) ? 8'd6 : (t >= 8'd50) ? 8'd5 :
				(t >= 8'd40) ? 8'd4 : (t >= 8'd30) ? 8'd3 : (t >= 8'd20) ? 8'd2 :
				(t >= 8'd10) ? 8'd1 : 8'd0);
		endcase
	end

	// memory port: one write, one registered read
	logic mwe;
	logic [11:0] maddr;
	logic [7:0] mwd;
	always_comb begin
		mwe = 1'b0; maddr = ia; mwd = 8'h00;
		raddr = ia;
		unique case (ctl.op)
			OP_FETCH_HI: raddr = pc_q;
			OP_FETCH_LO: raddr = pc_q + 12'd1;
			OP_MEMWR: begin mwe = 1'b1; maddr = it_q.mem_address; mwd = it_q.mem_data; end
			OP_BCD: begin mwe = 1'b1; mwd = bcd_d; end
			OP_DUMP: begin mwe = 1'b1; mwd = v_q[ci]; end
			default: ;
		endcase
		if (clr_busy_q) begin
			mwe = 1'b1; maddr = clr_q; mwd = font_byte(clr_q[6:0]);
			if (clr_q >= 12'd80) mwd = 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (mwe) mem[maddr] <= mwd;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0; clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 12'd1;
			if (clr_q == 12'(MEM_BYTES - 1)) clr_busy_q <= 1'b0;
		end
	end

	// sprite row XOR into the frame line
	wire [4:0] ry = vy[4:0] + ctl.cnt[4:0];
	logic [63:0] spr;
	always_comb begin
		spr = '0;
		for (int j = 0; j < 8; j++)
			if (rd_q[7-j]) spr[6'(63 - ((vx[5:0] + j) % 64))] = 1'b1;
	end

	logic [8:0] sum9;
	assign sum9 = {1'b0, vx} + {1'b0, vy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 32; k++) fb[k] <= '0;
			for (int k = 0; k < 16; k++) v_q[k] <= '0;
			for (int k = 0; k < STACK_DEPTH; k++) stk[k] <= '0;
			i_q <= '0; pc_q <= START_RST; lfsr_q <= SEED_RST; sp_q <= '0;
			dt_q <= '0; st_q <= '0; result_valid <= 1'b0;
			red_q <= 1'b0; wait_q <= 1'b0; bad_q <= 1'b0; hit_q <= 1'b0;
			it_q <= '0; op_q <= '0; row_q <= '0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_START) pc_q <= cfg_data[11:0];
				else lfsr_q <= cfg_data;
			end
			if (start && !busy) begin
				it_q <= in_item; red_q <= 1'b0; wait_q <= 1'b0; bad_q <= 1'b0;
				hit_q <= 1'b0; row_q <= '0;
			end
			unique case (ctl.op)
				OP_FETCH_HI: ;
				OP_FETCH_LO: op_q[15:8] <= rd_q;
				OP_DECODE: op_q[7:0] <= rd_q;
				OP_EXEC: begin
					pc_q <= nxt;
					unique case (op_q[15:12])
						4'h0: if (op_q == 16'h00E0) red_q <= 1'b1;
							else if (op_q == 16'h00EE) begin
								sp_q <= sp_q - 1'b1;
								pc_q <= stk[sp_q - 1'b1] + 12'd2;
							end else begin bad_q <= 1'b1; pc_q <= pc_q; end
						4'h1: pc_q <= op_q[11:0];
						4'h2: begin stk[sp_q] <= pc_q; sp_q <= sp_q + 1'b1;
							pc_q <= op_q[11:0]; end
						4'h3: if (vx == nn) pc_q <= skp;
						4'h4: if (vx != nn) pc_q <= skp;
						4'h5: if (n != 4'h0) begin bad_q <= 1'b1; pc_q <= pc_q; end
							else if (vx == vy) pc_q <= skp;
						4'h6: v_q[x] <= nn;
						4'h7: v_q[x] <= vx + nn;
						4'h8: unique case (n)
							4'h0: v_q[x] <= vy;
							4'h1: v_q[x] <= vx | vy;
							4'h2: v_q[x] <= vx & vy;
							4'h3: v_q[x] <= vx ^ vy;
							4'h4: begin v_q[x] <= sum9[7:0]; v_q[15] <= {7'd0, sum9[8]}; end
							4'h5: begin v_q[x] <= vx - vy; v_q[15] <= {7'd0, vx >= vy}; end
							4'h6: begin v_q[x] <= vx >> 1; v_q[15] <= {7'd0, vx[0]}; end
							4'h7: begin v_q[x] <= vy - vx; v_q[15] <= {7'd0, vy >= vx}; end
							4'hE: begin v_q[x] <= vx << 1; v_q[15] <= {7'd0, vx[7]}; end
							default: begin bad_q <= 1'b1; pc_q <= pc_q; end
						endcase
						4'h9: if (n != 4'h0) begin bad_q <= 1'b1; pc_q <= pc_q; end
							else if (vx != vy) pc_q <= skp;
						4'hA: i_q <= {4'd0, op_q[11:0]};
						4'hB: pc_q <= op_q[11:0] + {4'd0, v_q[0]};
						4'hC: begin
							lfsr_q <= lfsr_nx;
							v_q[x] <= lfsr_nx[7:0] & nn;
						end
						4'hD: red_q <= 1'b1;
						4'hE: begin
							if (nn == 8'h9E) begin if (it_q.key_mask[vx[3:0]]) pc_q <= skp; end
							else if (nn == 8'hA1) begin if (!it_q.key_mask[vx[3:0]]) pc_q <= skp; end
							else begin bad_q <= 1'b1; pc_q <= pc_q; end
						end
						default: unique case (nn)
							8'h07: v_q[x] <= dt_q;
							8'h0A: if (it_q.key_mask == 16'h0) begin
									wait_q <= 1'b1; pc_q <= pc_q;
								end else v_q[x] <= {4'd0, key_lo};
							8'h15: dt_q <= vx;
							8'h18: st_q <= vx;
							8'h1E: i_q <= i_q + {8'd0, vx};
							8'h29: i_q <= {10'd0, vx[3:0], 2'b00} + {12'd0, vx[3:0]};
							8'h33, 8'h55, 8'h65: ;
							default: begin bad_q <= 1'b1; pc_q <= pc_q; end
						endcase
					endcase
				end
				OP_CLS: fb[ctl.cnt[4:0]] <= '0;
				OP_SPR_RD: ;
				OP_SPR_ROW: begin
					if ((fb[ry] & spr) != '0) hit_q <= 1'b1;
					fb[ry] <= fb[ry] ^ spr;
				end
				OP_SPR_END: v_q[15] <= {7'd0, hit_q};
				OP_BCD: ;
				OP_DUMP: if (ctl.cnt[4:0] + 5'd1 == sts.len)
					i_q <= i_q + {11'd0, sts.len};
				OP_LOAD_RD: ;
				OP_LOAD_WR: begin
					v_q[ci] <= rd_q;
					if (ctl.cnt[4:0] + 5'd1 == sts.len) i_q <= i_q + {11'd0, sts.len};
				end
				OP_MEMWR: ;
				OP_ROWRD: row_q <= fb[it_q.display_row];
				OP_FINISH: begin
					result_valid <= 1'b1;
					if (it_q.cmd == CMD_EXEC) begin
						if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
						if (st_q != 8'd0) st_q <= st_q - 8'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		result.program_counter = pc_q;
		result.row_pixels = row_q;
		result.redraw = red_q;
		result.sound_on = (st_q != 8'd0);
		result.waiting_key = wait_q;
		result.bad_opcode = bad_q;
	end
endmodule
